>>> sv/assert_macros.svh
// assertion macros used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define BDM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define BDM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/bdm_pkg.sv
// shared constants for the binary descriptor majority block
package bdm_pkg;

  localparam int WORD_BITS       = 64;
  localparam int MAX_WORDS_DEF   = 4;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int INDEX_LIMIT     = 4;
  localparam int CFG_W           = 3;
  localparam int INDEX_W         = 2;

  localparam logic [CFG_W-1:0] DESC_WORDS_RESET = 3'd4;

  // command codes
  localparam logic CMD_ACCUM  = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

endpackage

>>> sv/binary_descriptor_majority_core.sv
// top level: bitwise majority mean of streamed binary descriptors
//
// input channel (in_valid_i / in_ready_o): one item is a command. cmd_i low
// adds word_data_i into the counter row word_index_i; a word whose index is
// not below the active word count is dropped. cmd_i high finishes the set.
// output channel (out_valid_o / out_ready_i): a finish gives one item per
// descriptor word, index ascending, last_word_o on the final one; a finish
// with no descriptors gives a single item with empty_set_o and last_word_o.
// cfg_we_i / cfg_wdata_i set the words per descriptor; the user must write
// them only while idle, and the block does not enforce this. an accumulate
// reads its row, then updates the lanes and writes back through the counter
// ram; in_ready_o is low until the write back. a dropped word makes no row
// update. each finish result passes the ram read and output registers.
// a stalled receiver holds the output register and the finish sweep waits;
// the next item is taken as soon as the last result is loaded.
// reset clears the row valid bits and the descriptor count, so the store
// reads as empty at once; no clearing pass is needed.
module binary_descriptor_majority_core #(
  parameter int MAX_WORDS  = bdm_pkg::MAX_WORDS_DEF,
  parameter int COUNT_BITS = bdm_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bdm_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [bdm_pkg::WORD_BITS-1:0]  word_data_i,
  input  logic [bdm_pkg::INDEX_W-1:0]    word_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bdm_pkg::WORD_BITS-1:0]  mean_word_o,
  output logic [bdm_pkg::INDEX_W-1:0]    mean_index_o,
  output logic                           last_word_o,
  output logic                           empty_set_o
);

  `include "assert_macros.svh"

  localparam int WB     = bdm_pkg::WORD_BITS;
  localparam int IW     = bdm_pkg::INDEX_W;
  localparam int CW     = bdm_pkg::CFG_W;
  localparam int ROW_W  = WB * COUNT_BITS;
  localparam int AW     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int LIM    = (MAX_WORDS < bdm_pkg::INDEX_LIMIT) ? MAX_WORDS
                                                             : bdm_pkg::INDEX_LIMIT;
  localparam logic [CW-1:0] LIM_W = CW'(LIM);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CW-1:0]         desc_words_q;
  logic [CW-1:0]         words;
  logic [COUNT_BITS-1:0] desc_cnt_q, desc_cnt_d;
  logic [COUNT_BITS-1:0] need_q;
  logic                  empty_q;
  logic [IW-1:0]         ptr_q, ptr_d;
  logic [MAX_WORDS-1:0]  row_valid_q, row_valid_d;
  logic [WB-1:0]         data_q;
  logic [AW-1:0]         idx_q;

  logic                  in_acc, acc_take, fin_take, idx_ok, idx_last;
  logic                  out_free, fin_load, fin_last;
  logic [COUNT_BITS:0]   need_wide;

  logic [AW-1:0]         raddr, rd_row;
  logic [ROW_W-1:0]      rdata, wdata;
  logic                  rd_valid;
  logic [WB-1:0]         mean_bits;

  logic                  out_valid_q;
  logic [WB-1:0]         mean_word_q;
  logic [IW-1:0]         mean_index_q;
  logic                  last_word_q, empty_set_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_words_q <= bdm_pkg::DESC_WORDS_RESET;
    end else if (cfg_we_i) begin
      desc_words_q <= cfg_wdata_i;
    end
  end

  // active word count, zero acts as one, clamped to the row count and the index limit
  always_comb begin
    words = desc_words_q;
    if (words == '0) begin
      words = CW'(1);
    end
    if (words > LIM_W) begin
      words = LIM_W;
    end
  end

  // handshake decode
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign idx_ok     = (CW'(word_index_i) < words);
  assign idx_last   = (CW'(word_index_i) == (words - CW'(1)));
  assign acc_take   = in_acc && (cmd_i == bdm_pkg::CMD_ACCUM) && idx_ok;
  assign fin_take   = in_acc && (cmd_i == bdm_pkg::CMD_FINISH);
  assign out_free   = !out_valid_q || out_ready_i;
  assign fin_load   = (state_q == S_FIN) && out_free;
  assign fin_last   = empty_q || (CW'(ptr_q) == (words - CW'(1)));

  // rounded-up half of the descriptor count
  assign need_wide = ({1'b0, desc_cnt_q} + (COUNT_BITS + 1)'(1)) >> 1;

  // sequencer and store bookkeeping
  always_comb begin
    state_d     = state_q;
    desc_cnt_d  = desc_cnt_q;
    ptr_d       = ptr_q;
    row_valid_d = row_valid_q;
    case (state_q)
      S_IDLE: begin
        if (acc_take) begin
          state_d = S_ACC;
          if (idx_last && (desc_cnt_q != {COUNT_BITS{1'b1}})) begin
            desc_cnt_d = desc_cnt_q + COUNT_BITS'(1);
          end
        end else if (fin_take) begin
          state_d    = S_FIN;
          desc_cnt_d = '0;
          ptr_d      = '0;
        end
      end
      S_ACC: begin
        state_d            = S_IDLE;
        row_valid_d[idx_q] = 1'b1;
      end
      S_FIN: begin
        if (fin_load) begin
          if (fin_last) begin
            state_d     = S_IDLE;
            row_valid_d = '0;
          end else begin
            ptr_d = ptr_q + IW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      desc_cnt_q  <= '0;
      ptr_q       <= '0;
      row_valid_q <= '0;
      empty_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      desc_cnt_q  <= desc_cnt_d;
      ptr_q       <= ptr_d;
      row_valid_q <= row_valid_d;
      if (fin_take) begin
        empty_q <= (desc_cnt_q == '0);
      end
    end
  end

  // captured item payload and finish threshold
  always_ff @(posedge clk_i) begin
    if (acc_take) begin
      data_q <= word_data_i;
      idx_q  <= AW'(word_index_i);
    end
    if (fin_take) begin
      need_q <= need_wide[COUNT_BITS-1:0];
    end
  end

  // ram read address: row of the new item, the first row on a finish, or the current or next row of the sweep
  always_comb begin
    case (state_q)
      S_IDLE:  raddr = (cmd_i == bdm_pkg::CMD_ACCUM) ? AW'(word_index_i) : '0;
      S_ACC:   raddr = idx_q;
      S_FIN:   raddr = (fin_load && !fin_last) ? AW'(ptr_q + IW'(1)) : AW'(ptr_q);
      default: raddr = '0;
    endcase
  end

  // row present in the read register, never-written rows read as zero
  assign rd_row   = (state_q == S_ACC) ? idx_q : AW'(ptr_q);
  assign rd_valid = row_valid_q[rd_row];

  bdm_ram #(
    .WIDTH  (ROW_W),
    .DEPTH  (MAX_WORDS),
    .ADDR_W (AW)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (state_q == S_ACC),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // one lane per bit position, shared by update and finish
  for (genvar l = 0; l < WB; l++) begin : g_lane
    logic [COUNT_BITS-1:0] cnt_in;
    assign cnt_in = rd_valid ? rdata[l*COUNT_BITS +: COUNT_BITS] : '0;
    bdm_lane #(
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .count_i (cnt_in),
      .bit_i   (data_q[l]),
      .need_i  (need_q),
      .count_o (wdata[l*COUNT_BITS +: COUNT_BITS]),
      .mean_o  (mean_bits[l])
    );
  end

  // merge lane results into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      mean_word_q  <= empty_q ? '0 : mean_bits;
      mean_index_q <= empty_q ? '0 : ptr_q;
      last_word_q  <= fin_last;
      empty_set_q  <= empty_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mean_word_o  = mean_word_q;
  assign mean_index_o = mean_index_q;
  assign last_word_o  = last_word_q;
  assign empty_set_o  = empty_set_q;

  // checks
  `BDM_ASSERT(a_fin_clears_count, clk_i, rst_ni, fin_take |=> (desc_cnt_q == '0), "finish did not clear the descriptor count")
  `BDM_ASSERT(a_acc_goes_update, clk_i, rst_ni, acc_take |=> (state_q == S_ACC), "accepted word did not start a row update")
  `BDM_ASSERT(a_empty_is_last, clk_i, rst_ni, (out_valid_o && empty_set_o) |-> (last_word_o && (mean_word_o == '0)), "empty result not flagged last or not zero")
  `BDM_ASSERT(a_sweep_clears_rows, clk_i, rst_ni, (fin_load && fin_last) |=> (row_valid_q == '0), "finish left rows marked written")

endmodule

>>> sv/bdm_ram.sv
// generic single write port ram with registered read
module bdm_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 4,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/bdm_lane.sv
// one bit position: saturating counter update and majority compare
module bdm_lane #(
  parameter int COUNT_BITS = bdm_pkg::COUNT_BITS_DEF
) (
  input  logic [COUNT_BITS-1:0] count_i,
  input  logic                  bit_i,
  input  logic [COUNT_BITS-1:0] need_i,
  output logic [COUNT_BITS-1:0] count_o,
  output logic                  mean_o
);

  // count stops at all ones
  assign count_o = (bit_i && (count_i != {COUNT_BITS{1'b1}})) ?
                   count_i + COUNT_BITS'(1) : count_i;

  // ties set the bit
  assign mean_o = (count_i >= need_i);

endmodule
